FILE: hw/rtl/polyline_band_clipper_defines.svh
// ----------------------------------------------------------------------------
// polyline_band_clipper_defines.svh
// Assertion macros for the polyline band clipper.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_BAND_CLIPPER_DEFINES_SVH
`define POLYLINE_BAND_CLIPPER_DEFINES_SVH

`ifndef ASSERT_OFF

// a must never hold
`define PBC_ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("never condition seen");

// a implies b in the same cycle
`define PBC_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication failed");

// a implies b on the next cycle
`define PBC_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`else

`define PBC_ASSERT_NEVER(label, clk, rst, a)
`define PBC_ASSERT_IMPLY(label, clk, rst, a, b)
`define PBC_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

FILE: hw/rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Command codes, register indexes and graph constants of the band clipper.
// ----------------------------------------------------------------------------
package pbc_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_MOVE   = 2'd0;
  localparam cmd_t CMD_DRAW   = 2'd1;
  localparam cmd_t CMD_STROKE = 2'd2;

  localparam int CFG_INDEX_WIDTH = 4;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_X_LOW  = 4'd0;
  localparam cfg_index_t REG_X_HIGH = 4'd1;
  localparam cfg_index_t REG_Y_LOW  = 4'd2;
  localparam cfg_index_t REG_Y_HIGH = 4'd3;

  localparam int GRAPH_SPAN_X = 1400;
  localparam int GRAPH_SPAN_Y = 1000;
  localparam int GRAPH_OFFSET = 100;

endpackage

FILE: hw/rtl/pbc_if.sv
// ----------------------------------------------------------------------------
// pbc_if
// Handshake channels of the band clipper: points in, commands out, config.
// ----------------------------------------------------------------------------
interface pbc_point_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          first_point;
  logic                          final_point;
  modport source (output valid, point_x, point_y, first_point, final_point, input ready);
  modport sink   (input valid, point_x, point_y, first_point, final_point, output ready);
endinterface

interface pbc_cmd_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [COORD_WIDTH-1:0] page_x;
  logic signed [COORD_WIDTH-1:0] page_y;
  logic                          run_end;
  modport source (output valid, command, page_x, page_y, run_end, input ready);
  modport sink   (input valid, command, page_x, page_y, run_end, output ready);
endinterface

interface pbc_cfg_if #(parameter int COORD_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [3:0]             index;
  logic [COORD_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/polyline_band_clipper.sv
// ----------------------------------------------------------------------------
// polyline_band_clipper
// Maps polyline points to page coordinates and clips each segment against
// the band 100..1100 in y, emitting move, draw and stroke commands.
// ----------------------------------------------------------------------------
// channel | dir | beat
// point   | in  | point_x, point_y, first_point, final_point
// cmd     | out | command, page_x, page_y, run_end (1..3 beats per point)
// cfg     | in  | index, data (x_low, x_high, y_low, y_high)
//
// One shared add/subtract unit does shift-add multiply and then restoring
// division on MW-bit operands, MW = max(W,FB)+12 (44 at Q16.16).
// A point runs two mappings plus one crossing when a band edge is passed;
// each is a multiply, then a division unless the divisor is zero.
// Points are taken only when idle; command beats hold while cmd stalls.
// Reset is synchronous and restores the default ranges (0.0 .. 1.0).
// ----------------------------------------------------------------------------
`include "polyline_band_clipper_defines.svh"

module polyline_band_clipper #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  pbc_point_if.sink   point,
  pbc_cmd_if.source   cmd,
  pbc_cfg_if.sink     cfg
);
  import pbc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int FB = FRACTION_BITS;
  // working width: holds any coordinate difference and span << FB
  localparam int MW = ((W > FB) ? W : FB) + 12;
  localparam int PW = 2 * MW;
  localparam int CW = $clog2(PW + 1);

  localparam logic signed [MW-1:0] LO_E   = MW'(GRAPH_OFFSET) << FB;
  localparam logic signed [MW-1:0] HI_E   = MW'(GRAPH_OFFSET + GRAPH_SPAN_Y) << FB;
  localparam logic        [MW-1:0] SPAN_X = MW'(GRAPH_SPAN_X) << FB;
  localparam logic        [MW-1:0] SPAN_Y = MW'(GRAPH_SPAN_Y) << FB;
  localparam logic        [MW-1:0] ONE_E  = MW'(1) << FB;
  localparam logic signed [W-1:0]  MAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MIN_W  = {1'b1, {(W-1){1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_PLAN = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // job codes for the shared unit
  localparam logic [1:0] J_MAPX  = 2'd0;
  localparam logic [1:0] J_MAPY  = 2'd1;
  localparam logic [1:0] J_CROSS = 2'd2;

  // segment cases
  localparam logic [1:0] C_MOVE  = 2'd0;
  localparam logic [1:0] C_DRAW  = 2'd1;
  localparam logic [1:0] C_EXIT  = 2'd2;
  localparam logic [1:0] C_ENTER = 2'd3;

  function automatic logic signed [MW-1:0] sx(input logic [W-1:0] v);
    return {{(MW-W){v[W-1]}}, v};
  endfunction

  function automatic logic [MW-1:0] dmag(input logic signed [MW-1:0] a,
                                         input logic signed [MW-1:0] b);
    return (a >= b) ? MW'(a - b) : MW'(b - a);
  endfunction

  function automatic logic signed [W-1:0] clamp_e(input logic signed [MW-1:0] v);
    if (v > sx(MAX_W)) return MAX_W;
    if (v < sx(MIN_W)) return MIN_W;
    return v[W-1:0];
  endfunction

  localparam logic signed [W-1:0] BASE_W = clamp_e(LO_E);

  // configuration
  logic [W-1:0] x_low, x_high, y_low, y_high;

  // item and state
  logic [W-1:0] in_y;
  logic         first_q, final_q;
  logic [W-1:0] nx, ny, prev_x, prev_y, cx;
  logic         have_previous;
  logic [1:0]   seg_case;
  logic         edge_hi;

  // shared unit
  logic [2:0]    state;
  logic [1:0]    job;
  logic [MW-1:0] hi, lo, b_op, c_op, r;
  logic [W:0]    q;
  logic          q_ovf, neg;
  logic [W-1:0]  base;
  logic [CW-1:0] cnt;

  // result beats
  cmd_t         ent_cmd [3];
  logic [W-1:0] ent_x [3];
  logic [W-1:0] ent_y [3];
  logic [1:0]   n_ent, k;

  // datapath
  logic [MW:0]          add_s, div_s;
  logic                 div_ge;
  logic signed [W+2:0]  off_s, base_x, q_x, max_x, min_x;
  logic signed [W-1:0]  off_res;
  logic signed [MW-1:0] ny_e, py_e, edge_e;
  logic                 out_n, out_p, in_n, in_p;
  logic                 stroke_beat, stroke_zero;

  assign add_s  = {1'b0, hi} + ((lo[0]) ? {1'b0, b_op} : '0);
  assign div_s  = {r, hi[MW-1]};
  assign div_ge = (div_s >= {1'b0, c_op});

  // base +/- quotient, three guard bits so the sum never wraps
  assign base_x = $signed({{3{base[W-1]}}, base});
  assign q_x    = $signed({2'b00, q});
  assign max_x  = $signed({3'b000, MAX_W});
  assign min_x  = $signed({3'b111, MIN_W});

  always_comb begin
    if (!neg) begin
      off_s = base_x + q_x;
      if (q_ovf || off_s > max_x) off_res = MAX_W;
      else off_res = off_s[W-1:0];
    end else begin
      off_s = base_x - q_x;
      if (q_ovf || off_s < min_x) off_res = MIN_W;
      else off_res = off_s[W-1:0];
    end
  end

  assign ny_e   = sx(ny);
  assign py_e   = sx(prev_y);
  assign edge_e = edge_hi ? HI_E : LO_E;
  assign out_n  = (ny_e > HI_E) || (ny_e < LO_E);
  assign out_p  = (py_e > HI_E) || (py_e < LO_E);
  assign in_n   = (ny_e > LO_E) && (ny_e < HI_E);
  assign in_p   = (py_e > LO_E) && (py_e < HI_E);

  assign point.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign cmd.valid   = (state == S_OUT);
  assign cmd.command = ent_cmd[k];
  assign cmd.page_x  = ent_x[k];
  assign cmd.page_y  = ent_y[k];
  assign cmd.run_end = (k == n_ent - 2'd1);

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= '0;
      x_high <= ONE_E[W-1:0];
      y_low  <= '0;
      y_high <= ONE_E[W-1:0];
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_X_LOW:  x_low  <= cfg.data;
        REG_X_HIGH: x_high <= cfg.data;
        REG_Y_LOW:  y_low  <= cfg.data;
        REG_Y_HIGH: y_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      have_previous <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      k             <= '0;
      n_ent         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (point.valid) begin
            in_y    <= point.point_y;
            first_q <= point.first_point;
            final_q <= point.final_point;
            // map x job
            job  <= J_MAPX;
            lo   <= dmag(sx(point.point_x), sx(x_low));
            hi   <= '0;
            b_op <= SPAN_X;
            c_op <= dmag(sx(x_high), sx(x_low));
            neg  <= (sx(point.point_x) < sx(x_low)) != (sx(x_high) < sx(x_low));
            base <= BASE_W;
            cnt  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          {hi, lo} <= {add_s, lo[MW-1:1]};
          if (cnt == CW'(MW - 1)) begin
            cnt   <= '0;
            r     <= '0;
            q     <= '0;
            q_ovf <= 1'b0;
            // empty range: offset by zero
            state <= (c_op == '0) ? S_FIN : S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          {hi, lo} <= {hi[MW-2:0], lo, 1'b0};
          r        <= div_ge ? MW'(div_s - {1'b0, c_op}) : div_s[MW-1:0];
          q        <= {q[W-1:0], div_ge};
          q_ovf    <= q_ovf | q[W];
          if (cnt == CW'(PW - 1)) state <= S_FIN;
          else cnt <= cnt + 1'b1;
        end
        S_FIN: begin
          case (job)
            J_MAPX: begin
              nx   <= off_res;
              job  <= J_MAPY;
              lo   <= dmag(sx(in_y), sx(y_low));
              hi   <= '0;
              b_op <= SPAN_Y;
              c_op <= dmag(sx(y_high), sx(y_low));
              neg  <= (sx(in_y) < sx(y_low)) != (sx(y_high) < sx(y_low));
              base <= BASE_W;
              cnt  <= '0;
              state <= S_MUL;
            end
            J_MAPY: begin
              ny    <= off_res;
              state <= S_PLAN;
            end
            default: begin
              cx    <= off_res;
              state <= S_FILL;
            end
          endcase
        end
        S_PLAN: begin
          if (first_q || !have_previous) begin
            seg_case <= C_MOVE;
            state    <= S_FILL;
          end else if (!out_n && !out_p) begin
            seg_case <= C_DRAW;
            state    <= S_FILL;
          end else if ((out_n && in_p) || (out_p && in_n)) begin
            // crossing: the edge passed is the one beyond the outside end
            seg_case <= out_n ? C_EXIT : C_ENTER;
            edge_hi  <= out_n ? (ny_e > HI_E) : (py_e > HI_E);
            job      <= J_CROSS;
            lo       <= dmag(sx(nx), sx(prev_x));
            hi       <= '0;
            b_op     <= dmag(out_n ? ((ny_e > HI_E) ? HI_E : LO_E)
                                   : ((py_e > HI_E) ? HI_E : LO_E), py_e);
            c_op     <= dmag(ny_e, py_e);
            neg      <= ((sx(nx) < sx(prev_x)) !=
                         ((out_n ? ((ny_e > HI_E) ? HI_E : LO_E)
                                 : ((py_e > HI_E) ? HI_E : LO_E)) < py_e))
                        != (ny_e < py_e);
            base     <= prev_x;
            cnt      <= '0;
            state    <= S_MUL;
          end else begin
            seg_case <= C_MOVE;
            state    <= S_FILL;
          end
        end
        S_FILL: begin
          case (seg_case)
            C_EXIT: begin
              ent_cmd[0] <= CMD_DRAW; ent_x[0] <= cx; ent_y[0] <= clamp_e(edge_e);
              ent_cmd[1] <= CMD_MOVE; ent_x[1] <= nx; ent_y[1] <= ny;
            end
            C_ENTER: begin
              ent_cmd[0] <= CMD_MOVE; ent_x[0] <= cx; ent_y[0] <= clamp_e(edge_e);
              ent_cmd[1] <= CMD_DRAW; ent_x[1] <= nx; ent_y[1] <= ny;
            end
            C_DRAW: begin
              ent_cmd[0] <= CMD_DRAW; ent_x[0] <= nx; ent_y[0] <= ny;
            end
            default: begin
              ent_cmd[0] <= CMD_MOVE; ent_x[0] <= nx; ent_y[0] <= ny;
            end
          endcase
          if (final_q) begin
            if (seg_case == C_EXIT || seg_case == C_ENTER) begin
              ent_cmd[2] <= CMD_STROKE; ent_x[2] <= '0; ent_y[2] <= '0;
              n_ent <= 2'd3;
            end else begin
              ent_cmd[1] <= CMD_STROKE; ent_x[1] <= '0; ent_y[1] <= '0;
              n_ent <= 2'd2;
            end
          end else begin
            n_ent <= (seg_case == C_EXIT || seg_case == C_ENTER) ? 2'd2 : 2'd1;
          end
          prev_x        <= nx;
          prev_y        <= ny;
          have_previous <= !final_q;
          k             <= '0;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (cmd.ready) begin
            if (k == n_ent - 2'd1) state <= S_IDLE;
            else k <= k + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  assign stroke_beat = cmd.valid && (cmd.command == CMD_STROKE);
  assign stroke_zero = (cmd.page_x == '0) && (cmd.page_y == '0);

  `PBC_ASSERT_NEVER(a_no_overlap, clk, rst, point.ready && cmd.valid)
  `PBC_ASSERT_IMPLY(a_stroke_ends, clk, rst, stroke_beat, cmd.run_end)
  `PBC_ASSERT_IMPLY(a_stroke_zero, clk, rst, stroke_beat, stroke_zero)
  `PBC_ASSERT_NEXT(a_busy_after_take, clk, rst, point.valid && point.ready, !point.ready)

endmodule

FILE: dv/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// Watches the point, command and config channels of the band clipper. Keeps
// its own copy of the ranges and the last page point, works out the commands
// each accepted point should cause and compares them beat by beat.
// ----------------------------------------------------------------------------
module pbc_checker
  import pbc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  pbc_point_if  point,
  pbc_cmd_if    cmd,
  pbc_cfg_if    cfg,
  output int    fail_count,
  output int    commands_due,
  output int    commands_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TOP   = 64'sh7FFF_FFFF;
  localparam longint BOT   = -TOP - 1;
  localparam longint EDGE_LO = longint'(GRAPH_OFFSET) <<< 16;
  localparam longint EDGE_HI = longint'(GRAPH_OFFSET + GRAPH_SPAN_Y) <<< 16;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] page_x;
    logic [31:0] page_y;
    logic        run_end;
  } page_cmd_t;

  page_cmd_t   cmd_queue[$];
  logic [31:0] range_reg [4];
  longint      last_x, last_y;
  bit          have_last;

  function automatic longint sat32(longint v);
    if (v > TOP) return TOP;
    if (v < BOT) return BOT;
    return v;
  endfunction

  function automatic void split_diff(input longint a, input longint b,
                                     output bit neg, output longint unsigned mag);
    neg = (a < b);
    mag = neg ? longint'(b - a) : longint'(a - b);
  endfunction

  // base +/- mag, saturated to 32-bit signed
  function automatic longint shift_sat(longint base_in, bit neg, longint unsigned mag);
    longint base;
    longint unsigned room;
    base = sat32(base_in);
    if (!neg) begin
      room = longint'(TOP - base);
      return (mag > room) ? TOP : base + longint'(mag);
    end
    room = longint'(base - BOT);
    return (mag > room) ? BOT : base - longint'(mag);
  endfunction

  // floor(a*b/c), saturating at 64 bits
  function automatic longint unsigned scale_div(longint unsigned a, longint unsigned b,
                                                longint unsigned c);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    if (c == 0 || prod[127:64] >= c) return '1;
    return 64'(prod / {64'd0, c});
  endfunction

  function automatic longint to_page(logic [31:0] v, logic [31:0] lo, logic [31:0] hi,
                                     int span);
    bit dn, en;
    longint unsigned dm, em;
    split_diff(longint'($signed(v)), longint'($signed(lo)), dn, dm);
    split_diff(longint'($signed(hi)), longint'($signed(lo)), en, em);
    if (em == 0) return EDGE_LO;
    return shift_sat(EDGE_LO, dn != en,
                     scale_div(dm, longint'(span) <<< 16, em));
  endfunction

  function automatic longint edge_cross_x(longint px, longint py, longint nx, longint ny,
                                          longint edge_y);
    bit xn, en, yn;
    longint unsigned xm, em, ym;
    split_diff(nx, px, xn, xm);
    split_diff(edge_y, py, en, em);
    split_diff(ny, py, yn, ym);
    if (ym == 0) return sat32(px);
    return shift_sat(px, (xn != en) != yn, scale_div(xm, em, ym));
  endfunction

  function automatic page_cmd_t mk(cmd_t c, longint x, longint y);
    mk.command = c;
    mk.page_x  = x[31:0];
    mk.page_y  = y[31:0];
    mk.run_end = 1'b0;
  endfunction

  task automatic predict_point(logic [31:0] px_in, logic [31:0] py_in, bit first, bit fin);
    page_cmd_t out[$];
    longint nx, ny, px, py;
    bit out_n, out_p, in_n, in_p;
    nx = to_page(px_in, range_reg[REG_X_LOW], range_reg[REG_X_HIGH], GRAPH_SPAN_X);
    ny = to_page(py_in, range_reg[REG_Y_LOW], range_reg[REG_Y_HIGH], GRAPH_SPAN_Y);
    px = last_x;
    py = last_y;
    out_n = ny > EDGE_HI || ny < EDGE_LO;
    out_p = py > EDGE_HI || py < EDGE_LO;
    in_n  = ny > EDGE_LO && ny < EDGE_HI;
    in_p  = py > EDGE_LO && py < EDGE_HI;
    if (first || !have_last) out.push_back(mk(CMD_MOVE, nx, ny));
    else if (!out_n && !out_p) out.push_back(mk(CMD_DRAW, nx, ny));
    else if (ny > EDGE_HI && in_p) begin
      out.push_back(mk(CMD_DRAW, edge_cross_x(px, py, nx, ny, EDGE_HI), EDGE_HI));
      out.push_back(mk(CMD_MOVE, nx, ny));
    end else if (ny < EDGE_LO && in_p) begin
      out.push_back(mk(CMD_DRAW, edge_cross_x(px, py, nx, ny, EDGE_LO), EDGE_LO));
      out.push_back(mk(CMD_MOVE, nx, ny));
    end else if (py > EDGE_HI && in_n) begin
      out.push_back(mk(CMD_MOVE, edge_cross_x(px, py, nx, ny, EDGE_HI), EDGE_HI));
      out.push_back(mk(CMD_DRAW, nx, ny));
    end else if (py < EDGE_LO && in_n) begin
      out.push_back(mk(CMD_MOVE, edge_cross_x(px, py, nx, ny, EDGE_LO), EDGE_LO));
      out.push_back(mk(CMD_DRAW, nx, ny));
    end else out.push_back(mk(CMD_MOVE, nx, ny));
    last_x = nx;
    last_y = ny;
    have_last = 1'b1;
    if (fin) begin
      out.push_back(mk(CMD_STROKE, 0, 0));
      have_last = 1'b0;
    end
    out[out.size()-1].run_end = 1'b1;
    foreach (out[i]) cmd_queue.push_back(out[i]);
  endtask

  assign commands_due = cmd_queue.size();

  always @(posedge clk) begin
    page_cmd_t want;
    if (rst) begin
      range_reg[REG_X_LOW]  <= 32'd0;
      range_reg[REG_X_HIGH] <= 32'h0001_0000;
      range_reg[REG_Y_LOW]  <= 32'd0;
      range_reg[REG_Y_HIGH] <= 32'h0001_0000;
      last_x = 0;
      last_y = 0;
      have_last = 1'b0;
      cmd_queue.delete();
      fail_count <= 0;
      commands_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index <= REG_Y_HIGH)
        range_reg[cfg.index] <= cfg.data;
      if (point.valid && point.ready)
        predict_point(point.point_x, point.point_y, point.first_point, point.final_point);
      if (cmd.valid && cmd.ready) begin
        commands_seen <= commands_seen + 1;
        if (cmd_queue.size() == 0) begin
          $error("command beat with nothing expected: cmd %0d", cmd.command);
          fail_count <= fail_count + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (cmd.command !== want.command || cmd.page_x !== want.page_x ||
              cmd.page_y !== want.page_y || cmd.run_end !== want.run_end)
            fail_count <= fail_count + 1;
          if (cmd.command !== want.command)
            $error("command: expected %0d, got %0d", want.command, cmd.command);
          if (cmd.page_x !== want.page_x)
            $error("page_x: expected %h, got %h", want.page_x, cmd.page_x);
          if (cmd.page_y !== want.page_y)
            $error("page_y: expected %h, got %h", want.page_y, cmd.page_y);
          if (cmd.run_end !== want.run_end)
            $error("run_end: expected %0b, got %0b", want.run_end, cmd.run_end);
        end
      end
    end
  end
endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the polyline band clipper. A directed set of
// points walks every clipping case under the reset ranges, then random
// polylines run through a series of range settings, extremes included, with
// random idle bursts on both channels. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;
  import pbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, commands_due, commands_seen;
  int   points_sent = 0;
  int   cycle_count = 0;
  bit   quiet = 1'b0;     // no idling at all, used for the closing stretch
  bit   sender_idles = 1'b1;
  int   stall_left = 0;

  pbc_point_if #(32) point_if ();
  pbc_cmd_if   #(32) cmd_if ();
  pbc_cfg_if   #(32) cfg_if ();

  polyline_band_clipper #(.COORD_WIDTH(32), .FRACTION_BITS(16)) dut (
    .clk   (clk),
    .rst   (rst),
    .point (point_if),
    .cmd   (cmd_if),
    .cfg   (cfg_if)
  );

  pbc_checker chk (
    .clk           (clk),
    .rst           (rst),
    .point         (point_if),
    .cmd           (cmd_if),
    .cfg           (cfg_if),
    .fail_count    (fail_count),
    .commands_due  (commands_due),
    .commands_seen (commands_seen)
  );

  always #5 clk = ~clk;

  // Timeout: fail the run once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still due", cycle_count,
               commands_due);
      $display("tb failed");
      $finish;
    end
  end

  // Command sink: ready drops in random bursts; none start while quiet is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      cmd_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && !rst && $urandom_range(0, 11) == 0) begin
      cmd_if.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 9) - 1;
    end else begin
      cmd_if.ready <= 1'b1;
    end
  end

  // Let the last point be registered, then wait until the block is idle and
  // every command of it is out.
  task automatic drain();
    @(posedge clk);
    while (commands_due != 0 || !point_if.ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ranges(logic [31:0] xl, logic [31:0] xh,
                            logic [31:0] yl, logic [31:0] yh);
    drain();
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, yh);
    // out-of-range index: must not disturb anything
    write_reg(cfg_index_t'($urandom_range(4, 15)), $urandom);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit first, bit fin);
    if (!quiet && sender_idles && $urandom_range(0, 4) == 0) begin
      point_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    point_if.valid       <= 1'b1;
    point_if.point_x     <= x;
    point_if.point_y     <= y;
    point_if.first_point <= first;
    point_if.final_point <= fin;
    do @(posedge clk); while (!point_if.ready);
    points_sent++;
  endtask

  // Data value at pct percent along [lo, hi], clamped to 32 bits.
  function automatic logic [31:0] along(logic [31:0] lo, logic [31:0] hi, int pct);
    longint v;
    v = longint'($signed(lo)) +
        (longint'($signed(hi)) - longint'($signed(lo))) * pct / 100;
    if (v > longint'($signed(Q_MAX))) v = longint'($signed(Q_MAX));
    if (v < longint'($signed(Q_MIN))) v = longint'($signed(Q_MIN));
    return v[31:0];
  endfunction

  // Mostly well-formed polylines with y around the band, some pure noise.
  task automatic random_polylines(int count, logic [31:0] xl, logic [31:0] xh,
                                  logic [31:0] yl, logic [31:0] yh);
    int sent, len;
    bit first, fin;
    logic [31:0] x, y;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      sender_idles = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          x = $urandom;
          y = $urandom;
        end else begin
          x = along(xl, xh, $urandom_range(0, 100));
          y = along(yl, yh, int'($urandom_range(0, 160)) - 30);
        end
        first = (i == 0) && ($urandom_range(0, 9) != 0);
        fin   = (i == len - 1);
        if ($urandom_range(0, 14) == 0) begin
          first = $urandom_range(0, 1);
          fin   = $urandom_range(0, 1);
        end
        send_point(x, y, first, fin);
        sent++;
      end
    end
  endtask

  initial begin
    point_if.valid       = 1'b0;
    point_if.point_x     = '0;
    point_if.point_y     = '0;
    point_if.first_point = 1'b0;
    point_if.final_point = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    cmd_if.ready         = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset ranges map 0.0..1.0 onto 100..1500 / 100..1100.
    send_point(32'h0000_1999, 32'h0000_8000, 1, 0); // move, inside
    send_point(32'h0000_3333, 32'h0000_999A, 0, 0); // draw inside
    send_point(32'h0000_4CCC, 32'h0001_3333, 0, 0); // leaves over top
    send_point(32'h0000_6666, 32'h0001_8000, 0, 0); // stays above
    send_point(32'h0000_8000, 32'h0000_8000, 0, 0); // enters from top
    send_point(32'h0000_999A, 32'hFFFF_CCCD, 0, 0); // leaves under bottom
    send_point(32'h0000_B333, 32'h0000_4CCC, 0, 0); // enters from bottom
    send_point(32'h0000_CCCC, 32'h0001_0000, 0, 0); // lands on top edge
    send_point(32'h0000_E666, 32'h0001_4CCC, 0, 0); // edge to outside
    send_point(32'h0000_E666, 32'hFFFF_B333, 0, 0); // jump across, vertical
    send_point(32'h0001_0000, 32'h0000_0000, 0, 0); // bottom edge
    send_point(Q_MIN, Q_MAX, 0, 1);                 // saturating, stroke
    send_point(Q_MAX, Q_MIN, 0, 0);                 // no first after stroke
    send_point(32'h0000_0000, 32'h0000_8000, 1, 0); // restart mid-line
    send_point(32'h0000_8000, Q_MAX, 0, 0);         // huge exit over top
    send_point(32'h0000_8000, 32'h0000_8000, 0, 0); // back in from far out
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1); // move then stroke
    point_if.valid <= 1'b0;

    // Hold the sender until every command is back before reconfiguring.
    set_ranges(32'hFFF6_0000, 32'h000A_0000, 32'hFFFB_0000, 32'h0005_0000);
    random_polylines(35, 32'hFFF6_0000, 32'h000A_0000, 32'hFFFB_0000, 32'h0005_0000);
    point_if.valid <= 1'b0;

    // reversed ranges
    set_ranges(32'h0064_0000, 32'h0000_0000, 32'h0003_0000, 32'hFFFD_0000);
    random_polylines(35, 32'h0064_0000, 32'h0000_0000, 32'h0003_0000, 32'hFFFD_0000);
    point_if.valid <= 1'b0;

    // widest possible ranges
    set_ranges(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    random_polylines(35, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    point_if.valid <= 1'b0;

    // empty ranges: everything maps to 100
    set_ranges(32'h1234_5678, 32'h1234_5678, Q_MAX, Q_MAX);
    random_polylines(15, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    point_if.valid <= 1'b0;

    // tiny y range, so slopes and crossings saturate
    set_ranges(Q_MAX, Q_MIN, 32'h0000_0000, 32'h0000_0001);
    random_polylines(30, Q_MAX, Q_MIN, 32'hFFFF_FFF0, 32'h0000_0010);
    point_if.valid <= 1'b0;

    // random ranges, last part with no idling on either side
    begin
      logic [31:0] xl, xh, yl, yh;
      xl = $urandom;
      xh = $urandom;
      yl = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      yh = yl + $urandom_range(1, 32'h00FF_FFFF);
      set_ranges(xl, xh, yl, yh);
      random_polylines(40, xl, xh, yl, yh);
      quiet = 1'b1;
      random_polylines(30, xl, xh, yl, yh);
    end
    point_if.valid <= 1'b0;

    drain();
    $display("covered %0d points and %0d commands over seven range settings",
             points_sent, commands_seen);
    $display("including reversed, empty and full-width ranges, with idle bursts");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_if.sv
hw/rtl/polyline_band_clipper.sv
dv/pbc_checker.sv
dv/tb.sv
